@@ hw/rtl/pib_pkg.sv @@
// Shared types and constants for the barycentric point-in-triangle block.
// No dependencies.
`default_nettype none

package pib_pkg;

	localparam int IN_BITS       = 16;
	localparam int W_BITS        = 20;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 48;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_A = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_B = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_VERTEX_C = 2'd2;

	localparam logic signed [W_BITS-1:0] W_MAX = 20'sd524287;
	localparam logic signed [W_BITS-1:0] W_MIN = -20'sd524288;

	// side flags that ride along with an item through the divider
	typedef struct packed {
		logic vld;
		logic degen;
		logic in_tri;
		logic neg_v;
		logic neg_w;
	} pib_flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/pib_mul.sv @@
// Two-stage signed multiplier: four half-width partial products, then a sum.
// No dependencies.
`default_nettype none

module pib_mul #(
	parameter int AW = 36,
	parameter int BW = 36
) (
	input  wire                        clk,
	input  wire  signed [AW-1:0]       a,
	input  wire  signed [BW-1:0]       b,
	output logic signed [AW+BW-1:0]    p
);

	localparam int LA = AW / 2;
	localparam int HA = AW - LA;
	localparam int LB = BW / 2;
	localparam int HB = BW - LB;
	localparam int PW = AW + BW;

	logic signed [LA:0]   al;
	logic signed [HA-1:0] ah;
	logic signed [LB:0]   bl;
	logic signed [HB-1:0] bh;

	logic signed [LA+LB+1:0]  pp_ll_s1;
	logic signed [LA+HB:0]    pp_lh_s1;
	logic signed [HA+LB:0]    pp_hl_s1;
	logic signed [HA+HB-1:0]  pp_hh_s1;
	logic signed [PW-1:0]     p_s2;

	// low halves are unsigned: a zero on top keeps them positive
	assign al = $signed({1'b0, a[LA-1:0]});
	assign ah = $signed(a[AW-1:LA]);
	assign bl = $signed({1'b0, b[LB-1:0]});
	assign bh = $signed(b[BW-1:LB]);

	always_ff @(posedge clk) begin
		pp_ll_s1 <= al * bl;
		pp_lh_s1 <= al * bh;
		pp_hl_s1 <= ah * bl;
		pp_hh_s1 <= ah * bh;
		p_s2 <= (PW'(pp_hh_s1) <<< (LA + LB)) + (PW'(pp_lh_s1) <<< LA)
			+ (PW'(pp_hl_s1) <<< LB) + PW'(pp_ll_s1);
	end

	assign p = p_s2;

endmodule

`default_nettype wire

@@ hw/rtl/pib_div.sv @@
// Two-lane restoring divider, one quotient bit per pipeline stage, shared divisor.
// Depends on pib_pkg for the side flag struct.
`default_nettype none

module pib_div
	import pib_pkg::*;
#(
	parameter int MB = 91,
	parameter int GW = 73
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire  [MB-1:0]     num_v,
	input  wire  [MB-1:0]     num_w,
	input  wire  [GW-1:0]     dsr,
	input  pib_flags_t        tag_in,
	output logic [MB-1:0]     quo_v,
	output logic [MB-1:0]     quo_w,
	output pib_flags_t        tag_out
);

	// [0] is the stage input, [MB] the last stage register
	logic [GW-1:0] rem_v [0:MB];
	logic [GW-1:0] rem_w [0:MB];
	logic [MB-1:0] nq_v  [0:MB];
	logic [MB-1:0] nq_w  [0:MB];
	logic [GW-1:0] dsr_p [0:MB];
	pib_flags_t    tag_p [0:MB];

	assign rem_v[0] = '0;
	assign rem_w[0] = '0;
	assign nq_v[0]  = num_v;
	assign nq_w[0]  = num_w;
	assign dsr_p[0] = dsr;
	assign tag_p[0] = tag_in;

	for (genvar i = 0; i < MB; i++) begin : g_stage
		logic [GW:0] tv, tw, dx, sv, sw;
		logic        gv, gw;

		assign tv = {rem_v[i], nq_v[i][MB-1]};
		assign tw = {rem_w[i], nq_w[i][MB-1]};
		assign dx = {1'b0, dsr_p[i]};
		assign gv = (tv >= dx);
		assign gw = (tw >= dx);
		assign sv = gv ? (tv - dx) : tv;
		assign sw = gw ? (tw - dx) : tw;

		always_ff @(posedge clk) begin
			rem_v[i+1] <= sv[GW-1:0];
			rem_w[i+1] <= sw[GW-1:0];
			nq_v[i+1]  <= {nq_v[i][MB-2:0], gv};
			nq_w[i+1]  <= {nq_w[i][MB-2:0], gw};
			dsr_p[i+1] <= dsr_p[i];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_p[i+1] <= '0;
			end else begin
				tag_p[i+1] <= tag_p[i];
			end
		end
	end

	assign quo_v   = nq_v[MB];
	assign quo_w   = nq_w[MB];
	assign tag_out = tag_p[MB];

endmodule

`default_nettype wire

@@ hw/rtl/point_in_triangle_barycentric_top.sv @@
// Top level of the barycentric point-in-triangle block.
// Depends on pib_pkg, pib_mul and pib_div.
//
// Usage:
//  - Load the triangle through the write port: cfg_we with cfg_index 0, 1
//    or 2 (vertex a, b, c), cfg_wdata packed {z,y,x}. Other indexes are
//    ignored. Write only while no query is in flight.
//  - A query transfer happens on a rising edge with start high and busy
//    low. busy is always low: a new point can enter on every clock.
//  - Each query gives one result: done is high for exactly one cycle with
//    weight_u/v/w (16 fraction bits, saturated), inside_res and degenerate.
//  - Pipeline: 7 arithmetic stages, one stage per quotient bit in the
//    divider, and the output register that drives done.
//  - Throughput: one point per clock, set by the fully pipelined
//    multipliers and the bit-per-stage divider.
//  - Reset clears the vertices to zero and empties the pipeline; no
//    result is produced from anything in flight.
//  - The receiver cannot stall, so results are never held back.
`default_nettype none

module point_in_triangle_barycentric_top
	import pib_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [CFG_IDX_BITS-1:0]      cfg_index,
	input  wire  [CFG_DATA_BITS-1:0]     cfg_wdata,
	input  wire                          start,
	output logic                         busy,
	input  wire  signed [IN_BITS-1:0]    query_x,
	input  wire  signed [IN_BITS-1:0]    query_y,
	input  wire  signed [IN_BITS-1:0]    query_z,
	output logic                         done,
	output logic signed [W_BITS-1:0]     weight_u,
	output logic signed [W_BITS-1:0]     weight_v,
	output logic signed [W_BITS-1:0]     weight_w,
	output logic                         inside_res,
	output logic                         degenerate
);

	localparam int CB  = COORD_BITS;
	localparam int EW  = CB + 1;           // edge vector component
	localparam int PW1 = 2 * EW;           // component product
	localparam int DW  = PW1 + 2;          // dot product
	localparam int GW  = 2 * DW + 1;       // den, nv, nw
	localparam int MB  = GW + FRAC_BITS + 2; // divider numerator / quotient
	localparam int XW  = MB + 3;           // unsaturated weights

	// ---------------- configuration ----------------
	logic [CFG_DATA_BITS-1:0] vtx_a_q, vtx_b_q, vtx_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_a_q <= '0;
			vtx_b_q <= '0;
			vtx_c_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VERTEX_A: vtx_a_q <= cfg_wdata;
				REG_VERTEX_B: vtx_b_q <= cfg_wdata;
				REG_VERTEX_C: vtx_c_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// coordinates above the 48 register bits read as zero
	logic [3*CB-1:0] wa, wb, wc;
	assign wa = (3*CB)'(vtx_a_q);
	assign wb = (3*CB)'(vtx_b_q);
	assign wc = (3*CB)'(vtx_c_q);

	logic signed [CB-1:0] ca [3];
	logic signed [CB-1:0] cbv [3];
	logic signed [CB-1:0] cc [3];
	logic signed [CB-1:0] cq [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ca[k]  = $signed(wa[k*CB +: CB]);
			cbv[k] = $signed(wb[k*CB +: CB]);
			cc[k]  = $signed(wc[k*CB +: CB]);
		end
		cq[0] = $signed(CB'($unsigned(query_x)));
		cq[1] = $signed(CB'($unsigned(query_y)));
		cq[2] = $signed(CB'($unsigned(query_z)));
	end

	assign busy = 1'b0;

	logic acc;
	assign acc = start && !busy;

	// ---------------- stage 1: edge vectors ----------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [EW-1:0] e0_s1 [3];
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			e0_s1[k] <= EW'(cbv[k]) - EW'(ca[k]);
			e1_s1[k] <= EW'(cc[k]) - EW'(ca[k]);
			e2_s1[k] <= EW'(cq[k]) - EW'(ca[k]);
		end
	end

	// ---------------- stage 2: component products ----------------
	logic signed [PW1-1:0] p00_s2 [3];
	logic signed [PW1-1:0] p01_s2 [3];
	logic signed [PW1-1:0] p11_s2 [3];
	logic signed [PW1-1:0] p20_s2 [3];
	logic signed [PW1-1:0] p21_s2 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			p00_s2[k] <= e0_s1[k] * e0_s1[k];
			p01_s2[k] <= e0_s1[k] * e1_s1[k];
			p11_s2[k] <= e1_s1[k] * e1_s1[k];
			p20_s2[k] <= e2_s1[k] * e0_s1[k];
			p21_s2[k] <= e2_s1[k] * e1_s1[k];
		end
	end

	// ---------------- stage 3: dot products ----------------
	logic signed [DW-1:0] d00_s3, d01_s3, d11_s3, d20_s3, d21_s3;

	always_ff @(posedge clk) begin
		d00_s3 <= DW'(p00_s2[0]) + DW'(p00_s2[1]) + DW'(p00_s2[2]);
		d01_s3 <= DW'(p01_s2[0]) + DW'(p01_s2[1]) + DW'(p01_s2[2]);
		d11_s3 <= DW'(p11_s2[0]) + DW'(p11_s2[1]) + DW'(p11_s2[2]);
		d20_s3 <= DW'(p20_s2[0]) + DW'(p20_s2[1]) + DW'(p20_s2[2]);
		d21_s3 <= DW'(p21_s2[0]) + DW'(p21_s2[1]) + DW'(p21_s2[2]);
	end

	// ---------------- stages 4-5: Gram products ----------------
	// 0: d00*d11  1: d01*d01  2: d11*d20  3: d01*d21  4: d00*d21  5: d01*d20
	logic signed [DW-1:0]   ma [6];
	logic signed [DW-1:0]   mb [6];
	logic signed [2*DW-1:0] mp [6];

	assign ma[0] = d00_s3; assign mb[0] = d11_s3;
	assign ma[1] = d01_s3; assign mb[1] = d01_s3;
	assign ma[2] = d11_s3; assign mb[2] = d20_s3;
	assign ma[3] = d01_s3; assign mb[3] = d21_s3;
	assign ma[4] = d00_s3; assign mb[4] = d21_s3;
	assign ma[5] = d01_s3; assign mb[5] = d20_s3;

	for (genvar j = 0; j < 6; j++) begin : g_mul
		pib_mul #(.AW(DW), .BW(DW)) u_mul (
			.clk (clk),
			.a   (ma[j]),
			.b   (mb[j]),
			.p   (mp[j])
		);
	end

	// ---------------- stage 6: den, nv, nw ----------------
	logic signed [GW-1:0] den_s6, nv_s6, nw_s6;

	always_ff @(posedge clk) begin
		den_s6 <= GW'(mp[0]) - GW'(mp[1]);
		nv_s6  <= GW'(mp[2]) - GW'(mp[3]);
		nw_s6  <= GW'(mp[4]) - GW'(mp[5]);
	end

	// ---------------- stage 7: inside test, divider operands ----------------
	logic signed [GW+1:0] nu_c, den_x;
	logic [GW-1:0]        mag_v, mag_w;
	logic                 deg_c, in_c;

	always_comb begin
		den_x = (GW+2)'(den_s6);
		nu_c  = den_x - (GW+2)'(nv_s6) - (GW+2)'(nw_s6);
		deg_c = (den_s6 <= 0);
		in_c  = !deg_c && (nv_s6 >= 0) && (nv_s6 <= den_s6)
			&& (nw_s6 >= 0) && (nw_s6 <= den_s6)
			&& (nu_c >= 0) && (nu_c <= den_x);
		mag_v = nv_s6[GW-1] ? $unsigned(-nv_s6) : $unsigned(nv_s6);
		mag_w = nw_s6[GW-1] ? $unsigned(-nw_s6) : $unsigned(nw_s6);
	end

	pib_flags_t    flg_s7;
	logic [MB-1:0] num_v_s7, num_w_s7;
	logic [GW-1:0] dsr_s7;

	// round to nearest, ties away: (|n|*2^F + den/2) / den == (|n|*2^(F+1)+den)/(2den)
	always_ff @(posedge clk) begin
		num_v_s7 <= (MB'(mag_v) << (FRAC_BITS + 1)) + MB'($unsigned(den_s6));
		num_w_s7 <= (MB'(mag_w) << (FRAC_BITS + 1)) + MB'($unsigned(den_s6));
		dsr_s7   <= {den_s6[GW-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			flg_s7 <= '0;
		end else begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			flg_s7.vld    <= vld_s6;
			flg_s7.degen  <= deg_c;
			flg_s7.in_tri <= in_c;
			flg_s7.neg_v  <= nv_s6[GW-1];
			flg_s7.neg_w  <= nw_s6[GW-1];
		end
	end

	// ---------------- divider ----------------
	logic [MB-1:0] quo_v, quo_w;
	pib_flags_t    flg_d;

	pib_div #(.MB(MB), .GW(GW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.num_v   (num_v_s7),
		.num_w   (num_w_s7),
		.dsr     (dsr_s7),
		.tag_in  (flg_s7),
		.quo_v   (quo_v),
		.quo_w   (quo_w),
		.tag_out (flg_d)
	);

	// ---------------- output stage: sign, u, saturation ----------------
	logic signed [XW-1:0]     vr_x, wr_x, ur_x, one_x;
	logic signed [W_BITS-1:0] su, sv, sw;

	always_comb begin
		vr_x  = flg_d.neg_v ? -$signed(XW'(quo_v)) : $signed(XW'(quo_v));
		wr_x  = flg_d.neg_w ? -$signed(XW'(quo_w)) : $signed(XW'(quo_w));
		one_x = $signed(XW'(1) << FRAC_BITS);
		ur_x  = one_x - vr_x - wr_x;
		su = (ur_x > XW'(W_MAX)) ? W_MAX : (ur_x < XW'(W_MIN)) ? W_MIN : ur_x[W_BITS-1:0];
		sv = (vr_x > XW'(W_MAX)) ? W_MAX : (vr_x < XW'(W_MIN)) ? W_MIN : vr_x[W_BITS-1:0];
		sw = (wr_x > XW'(W_MAX)) ? W_MAX : (wr_x < XW'(W_MIN)) ? W_MIN : wr_x[W_BITS-1:0];
	end

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= flg_d.vld;
		end
	end

	// degenerate triangle: zero weights, never inside
	always_ff @(posedge clk) begin
		weight_u   <= flg_d.degen ? '0 : su;
		weight_v   <= flg_d.degen ? '0 : sv;
		weight_w   <= flg_d.degen ? '0 : sw;
		inside_res <= flg_d.in_tri && !flg_d.degen;
		degenerate <= flg_d.degen;
	end

	assign done = done_q;

endmodule

`default_nettype wire
